FILE: hw/rtl/ue_context_table_core_assert.svh
// Assertion macros for the context table.
`ifndef UE_CONTEXT_TABLE_CORE_ASSERT_SVH
`define UE_CONTEXT_TABLE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define UCT_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define UCT_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define UCT_ASSERT_IMP(lbl, a, c)
`define UCT_ASSERT_NXT(lbl, a, c)
`endif
`endif

FILE: hw/rtl/uct_pkg.sv
// ----------------------------------------------------------------------------
// uct_pkg
// Types and constants shared by the context table.
// ----------------------------------------------------------------------------
package uct_pkg;
  localparam int NUM_UE_DEF       = 16;
  localparam int NUM_CARRIERS_DEF = 2;

  localparam logic [1:0] FUNC_ADD    = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_FIND   = 2'd2;
  localparam logic [1:0] FUNC_SREQ   = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] radio_id;
    logic        carrier;
    logic [3:0]  ue_index;
  } uct_req_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] result_index;
    logic [4:0] active_count;
  } uct_rsp_t;
endpackage

FILE: hw/rtl/uct_stream_if.sv
// ----------------------------------------------------------------------------
// uct_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface uct_stream_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/uct_ram.sv
// ----------------------------------------------------------------------------
// uct_ram
// Generic single-port RAM, registered read.
// ----------------------------------------------------------------------------
module uct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

FILE: hw/rtl/ue_context_table_core.sv
// ----------------------------------------------------------------------------
// ue_context_table_core
// Context table with free and active linked lists in RAM.
// ----------------------------------------------------------------------------
// One request beat is handled at a time. Each context's link, identifier and
// primary carrier share one RAM word (one access per cycle, registered read).
// A list walk checks one entry per cycle: the link that comes back from the
// RAM addresses the next read in the same cycle. Add takes the free head and
// makes it the active head; find and scheduling request walk the active list
// from the head until a match or its end; remove reads and clears the target,
// then walks the active list to unlink it and puts it at the free head.
// A failed add, or a find on an empty list, answers with no RAM read; a remove
// on an empty list answers after the target is cleared. The block goes back
// to idle in the cycle after the response beat is taken. The result is held
// until taken, and no new beat is accepted meanwhile. Per-carrier request and
// uplink flags, in-use and waiting bits are flip-flops cleared at reset. After
// reset the RAM is initialized by a sweep over all NUM_UE entries (free chain
// in index order) during which no request is accepted.
module ue_context_table_core import uct_pkg::*; #(
  parameter int NUM_UE       = NUM_UE_DEF,
  parameter int NUM_CARRIERS = NUM_CARRIERS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  uct_stream_if.sink   in_ch,
  uct_stream_if.source out_ch
);
  `include "ue_context_table_core_assert.svh"

  localparam int AW = $clog2(NUM_UE);
  localparam int LW = AW + 1;
  localparam int CW = (NUM_CARRIERS > 1) ? $clog2(NUM_CARRIERS) : 1;
  localparam int WW = LW + 16 + CW;
  localparam int CNTW = $clog2(NUM_UE + 1);
  localparam int FW = $clog2(NUM_CARRIERS * NUM_UE);
  localparam logic [LW-1:0] LNULL = LW'(NUM_UE);

  typedef enum logic [7:0] {
    S_INIT = 8'b00000001, S_IDLE = 8'b00000010, S_RD   = 8'b00000100,
    S_CHK  = 8'b00001000, S_RDUE = 8'b00010000, S_CLR  = 8'b00100000,
    S_WRN  = 8'b01000000, S_OUT  = 8'b10000000
  } state_t;

  state_t st_r;
  uct_req_t req_r;
  logic [LW-1:0] ahead_r, fhead_r, node_r, prev_r;
  logic [15:0] prid_r;
  logic [CW-1:0] pcc_r, ncc_r;
  logic [CNTW-1:0] cnt_r;
  logic [AW:0] steps_r;
  logic [AW-1:0] init_r;
  logic [NUM_UE-1:0] in_use_r, wait_r;
  logic [NUM_CARRIERS*NUM_UE-1:0] reqp_r, ulact_r;
  logic out_v_r;
  uct_rsp_t rsp_r;

  logic we;
  logic [AW-1:0] addr;
  logic [WW-1:0] wdata, rdata;
  logic [LW-1:0] r_link;
  logic [15:0] r_rid;
  logic [CW-1:0] r_cc;
  logic [AW-1:0] ue_a, node_a;
  logic cc_ok, r_cc_ok, walk_more, rid_hit, ue_hit;
  logic [FW-1:0] clr_fi, set_fi;

  assign r_link = rdata[WW-1 -: LW];
  assign r_rid  = rdata[CW +: 16];
  assign r_cc   = rdata[CW-1:0];

  uct_ram #(.WIDTH(WW), .DEPTH(NUM_UE)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  assign in_ch.ready  = (st_r == S_IDLE);
  assign out_ch.valid = out_v_r;
  assign out_ch.data  = rsp_r;

  assign ue_a      = AW'(req_r.ue_index);
  assign node_a    = node_r[AW-1:0];
  assign cc_ok     = (32'(req_r.carrier) < NUM_CARRIERS);
  assign r_cc_ok   = (32'(r_cc) < NUM_CARRIERS);
  // next link present and step budget not used up
  assign walk_more = (r_link < LNULL) && (32'(steps_r) + 1 < NUM_UE);
  assign rid_hit   = (r_rid == req_r.radio_id);
  assign ue_hit    = (node_a == ue_a);
  assign clr_fi    = FW'(32'(r_cc) * NUM_UE + 32'(ue_a));
  assign set_fi    = FW'(32'(req_r.carrier) * NUM_UE + 32'(node_a));

  // RAM port control
  always_comb begin
    we = 1'b0; addr = node_a; wdata = '0;
    case (st_r)
      S_INIT: begin
        we = 1'b1; addr = init_r;
        wdata = {LW'(32'(init_r) + 1), 16'd0, CW'(0)};
      end
      S_RDUE: addr = ue_a;
      S_CLR: begin
        // target keeps its link and carrier, identifier dropped
        we = 1'b1; addr = ue_a; wdata = {r_link, 16'd0, r_cc};
      end
      S_CHK: begin
        // walk: the returned link addresses the next read
        addr = r_link[AW-1:0];
        if (req_r.func == FUNC_ADD) begin
          we = 1'b1; addr = node_a;
          wdata = {ahead_r, req_r.radio_id, CW'(req_r.carrier)};
        end else if (req_r.func == FUNC_REMOVE && ue_hit && prev_r != LNULL) begin
          // predecessor skips over the target
          we = 1'b1; addr = prev_r[AW-1:0]; wdata = {r_link, prid_r, pcc_r};
        end
      end
      S_WRN: begin
        we = 1'b1; addr = node_a; wdata = {fhead_r, 16'd0, ncc_r};
      end
      default: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_INIT; init_r <= '0; out_v_r <= 1'b0; rsp_r <= '0;
      req_r <= '0; node_r <= '0; prev_r <= LNULL; steps_r <= '0;
      prid_r <= '0; pcc_r <= '0; ncc_r <= '0;
      ahead_r <= LNULL; fhead_r <= '0; cnt_r <= '0;
      in_use_r <= '0; wait_r <= '0; reqp_r <= '0; ulact_r <= '0;
    end else begin
      case (st_r)
        S_INIT: begin
          init_r <= init_r + 1'b1;
          if (32'(init_r) == NUM_UE - 1) st_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            req_r <= in_ch.data;
            steps_r <= '0;
            prev_r <= LNULL;
            rsp_r.ok <= 1'b0;
            rsp_r.result_index <= 4'd0;
            rsp_r.active_count <= 5'(cnt_r);
            case (in_ch.data.func)
              FUNC_ADD: begin
                node_r <= fhead_r;
                if (fhead_r < LNULL && 32'(in_ch.data.carrier) < NUM_CARRIERS) begin
                  st_r <= S_RD;
                end else begin
                  st_r <= S_OUT; out_v_r <= 1'b1;
                end
              end
              FUNC_REMOVE: begin
                if (32'(in_ch.data.ue_index) < NUM_UE) begin
                  st_r <= S_RDUE;
                end else begin
                  st_r <= S_OUT; out_v_r <= 1'b1;
                end
              end
              default: begin
                node_r <= ahead_r;
                if (ahead_r < LNULL) begin
                  st_r <= S_RD;
                end else begin
                  st_r <= S_OUT; out_v_r <= 1'b1;
                end
              end
            endcase
          end
        end
        S_RDUE: st_r <= S_CLR;
        S_CLR: begin
          // target entry is on rdata: drop waiting and its carrier flags
          wait_r[ue_a] <= 1'b0;
          if (r_cc_ok) begin
            reqp_r[clr_fi]  <= 1'b0;
            ulact_r[clr_fi] <= 1'b0;
          end
          node_r <= ahead_r;
          if (ahead_r < LNULL) begin
            st_r <= S_RD;
          end else begin
            st_r <= S_OUT; out_v_r <= 1'b1;
          end
        end
        S_RD: st_r <= S_CHK;
        S_CHK: begin
          case (req_r.func)
            FUNC_ADD: begin
              fhead_r <= r_link; ahead_r <= node_r;
              in_use_r[node_a] <= 1'b1; wait_r[node_a] <= 1'b1;
              cnt_r <= cnt_r + 1'b1;
              rsp_r.ok <= 1'b1; rsp_r.result_index <= 4'(node_r);
              rsp_r.active_count <= 5'(cnt_r + 1'b1);
              st_r <= S_OUT; out_v_r <= 1'b1;
            end
            FUNC_REMOVE: begin
              if (ue_hit) begin
                if (prev_r == LNULL) ahead_r <= r_link;
                ncc_r <= r_cc;
                st_r <= S_WRN;
              end else begin
                prev_r <= node_r; prid_r <= r_rid; pcc_r <= r_cc;
                node_r <= r_link; steps_r <= steps_r + 1'b1;
                if (!walk_more) begin
                  st_r <= S_OUT; out_v_r <= 1'b1;
                end
              end
            end
            default: begin
              if (rid_hit) begin
                rsp_r.ok <= 1'b1; rsp_r.result_index <= 4'(node_r);
                if (req_r.func == FUNC_SREQ && cc_ok) begin
                  reqp_r[set_fi]  <= 1'b1;
                  ulact_r[set_fi] <= 1'b1;
                end
                st_r <= S_OUT; out_v_r <= 1'b1;
              end else begin
                node_r <= r_link; steps_r <= steps_r + 1'b1;
                if (!walk_more) begin
                  st_r <= S_OUT; out_v_r <= 1'b1;
                end
              end
            end
          endcase
        end
        S_WRN: begin
          // unlinked entry goes to the free head
          fhead_r <= node_r; in_use_r[node_a] <= 1'b0;
          if (cnt_r != '0) cnt_r <= cnt_r - 1'b1;
          rsp_r.ok <= 1'b1; rsp_r.result_index <= req_r.ue_index;
          rsp_r.active_count <= 5'(cnt_r - CNTW'(cnt_r != '0));
          st_r <= S_OUT; out_v_r <= 1'b1;
        end
        S_OUT: begin
          if (out_ch.ready) begin
            out_v_r <= 1'b0; st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  `UCT_ASSERT_IMP(a_ready_idle, in_ch.ready, st_r == S_IDLE)
  `UCT_ASSERT_NXT(a_accept_busy, in_ch.valid && in_ch.ready, !in_ch.ready)
  `UCT_ASSERT_NXT(a_out_hold, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.data))
  `UCT_ASSERT_IMP(a_cnt_range, 1'b1, 32'(cnt_r) <= NUM_UE)
endmodule
